>>> hdl/pdbrf_pkg.sv
// shared constants for the packet drop byte ring fifo
// request codes, status codes and field widths; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pdbrf_pkg;

	// default configuration
	localparam int DEPTH_DEF      = 4096;
	localparam int READ_LIMIT_DEF = 64;

	// fixed field widths
	localparam int REQ_W   = 3;
	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 12;
	localparam int RMAX_W  = 7;
	localparam int STAT_W  = 3;

	// request codes
	localparam logic [REQ_W-1:0] REQ_WRITE = 3'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 3'd1;
	localparam logic [REQ_W-1:0] REQ_EOS   = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SHUT  = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd4;

	// status codes
	localparam logic [STAT_W-1:0] ST_ACCEPT = 3'd0;
	localparam logic [STAT_W-1:0] ST_DROP   = 3'd1;
	localparam logic [STAT_W-1:0] ST_DATA   = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd3;
	localparam logic [STAT_W-1:0] ST_EOS    = 3'd4;
	localparam logic [STAT_W-1:0] ST_SHUT   = 3'd5;

endpackage

`default_nettype wire

>>> hdl/pdbrf_mem.sv
// byte store of the ring fifo: one write port, one read port
// read data is registered; uses pdbrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdbrf_mem #(
	parameter int DEPTH = pdbrf_pkg::DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [AW-1:0]                 waddr,
	input  wire logic [pdbrf_pkg::BYTE_W-1:0]  wdata,
	input  wire logic                          re,
	input  wire logic [AW-1:0]                 raddr,
	output logic      [pdbrf_pkg::BYTE_W-1:0]  rdata
);

	logic [pdbrf_pkg::BYTE_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/packet_drop_byte_ring_fifo.sv
// top level of the packet drop byte ring fifo: request decode, pointers, read sequencer
// depends on pdbrf_pkg and pdbrf_mem
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A request word is taken at a rising edge where start is high and busy is low.
// Results come out on status/out_byte/run_last/byte_count/occupancy for one
// cycle each, marked by done; the receiver cannot hold them off.
// Write bytes (one per word) need no wait: busy stays low, and the accepted or
// dropped result of a packet appears the cycle after its last byte.
// A read of n bytes (n = min(read_max, READ_LIMIT, occupancy)) runs as follows:
// the first byte is fetched in the accept cycle, then busy is high while the
// remaining bytes are fetched from the store, one byte a cycle; each byte shows on
// the outputs in the cycle after its fetch (the store's read latency).
// Status results (empty, end of stream, shutdown) appear the cycle after accept.
// End of stream, shutdown and clear give no result.
// Throughput: one write byte per cycle while busy is low; a read run holds off new
// request words while busy, as the byte store has a single read port.
// Reset clears pointers, counters and flags; store contents stay undefined
// and are only read after being written.

module packet_drop_byte_ring_fifo #(
	parameter int DEPTH      = pdbrf_pkg::DEPTH_DEF,
	parameter int READ_LIMIT = pdbrf_pkg::READ_LIMIT_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [pdbrf_pkg::REQ_W-1:0]   req_type,
	input  wire logic [pdbrf_pkg::BYTE_W-1:0]  data_byte,
	input  wire logic                          pkt_start,
	input  wire logic [pdbrf_pkg::LEN_W-1:0]   pkt_len,
	input  wire logic [pdbrf_pkg::RMAX_W-1:0]  read_max,
	output logic                               done,
	output logic [pdbrf_pkg::STAT_W-1:0]       status,
	output logic [pdbrf_pkg::BYTE_W-1:0]       out_byte,
	output logic                               run_last,
	output logic [pdbrf_pkg::LEN_W-1:0]        byte_count,
	output logic [pdbrf_pkg::LEN_W-1:0]        occupancy
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = (AW > pdbrf_pkg::LEN_W) ? AW : pdbrf_pkg::LEN_W;
	localparam int LW = pdbrf_pkg::LEN_W;
	localparam int RW = pdbrf_pkg::RMAX_W;

	typedef enum logic {S_IDLE, S_READ} state_t;

	state_t        state_q;
	logic [AW-1:0] rp_q;
	logic [AW-1:0] cwp_q;
	logic [AW-1:0] twp_q;
	logic [AW-1:0] held_q;
	logic [LW-1:0] left_q;
	logic [LW-1:0] total_q;
	logic          drop_q;
	logic          eos_q;
	logic          shut_q;
	logic [RW-1:0] cnt_q;
	logic          byte_sel_q;

	logic [pdbrf_pkg::BYTE_W-1:0] mem_rdata;

	// pointer step with wrap at the ring size
	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + AW'(1);
		end
		return r;
	endfunction

	logic          accept;
	logic          is_wr;
	logic          start_zero;
	logic          wr_active;
	logic [AW-1:0] free_sp;
	logic          drop_new;
	logic [AW-1:0] eff_twp;
	logic          eff_drop;
	logic [LW-1:0] eff_left;
	logic [LW-1:0] eff_total;
	logic [LW-1:0] left_next;
	logic          wr_mem;
	logic [AW-1:0] twp_next;
	logic          finish;
	logic          rd_req;
	logic          rd_data;
	logic [RW-1:0] lim;
	logic [RW-1:0] n_rd;
	logic          issue;
	logic [RW-1:0] remain;
	logic [AW-1:0] held_commit;
	logic [AW-1:0] held_read;

	assign busy   = (state_q == S_READ);
	assign accept = start && !busy;

	// write path: start byte sets up a new packet, later bytes continue it
	always_comb begin
		is_wr      = accept && (req_type == pdbrf_pkg::REQ_WRITE);
		start_zero = pkt_start && (pkt_len == '0);
		wr_active  = is_wr && !start_zero && (pkt_start || (left_q != '0));
		free_sp    = AW'(DEPTH - 1) - held_q;
		drop_new   = CW'(pkt_len) > CW'(free_sp);
		if (pkt_start) begin
			eff_twp   = cwp_q;
			eff_drop  = drop_new;
			eff_left  = pkt_len;
			eff_total = pkt_len;
		end else begin
			eff_twp   = twp_q;
			eff_drop  = drop_q;
			eff_left  = left_q;
			eff_total = total_q;
		end
		left_next   = eff_left - LW'(1);
		wr_mem      = wr_active && !eff_drop;
		twp_next    = wr_mem ? ptr_inc(eff_twp) : eff_twp;
		finish      = wr_active && (left_next == '0);
		held_commit = held_q + AW'(eff_total);
	end

	// read path: byte count of a run and fetch control
	always_comb begin
		rd_req  = accept && (req_type == pdbrf_pkg::REQ_READ) && (read_max != '0);
		rd_data = rd_req && !shut_q && (held_q != '0);
		lim     = (read_max < RW'(READ_LIMIT)) ? read_max : RW'(READ_LIMIT);
		n_rd    = (CW'(held_q) < CW'(lim)) ? RW'(held_q) : lim;
		issue   = rd_data || (state_q == S_READ);
		remain  = (state_q == S_READ) ? cnt_q : n_rd;
		held_read = held_q - AW'(n_rd);
	end

	// state, pointers and registered results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			rp_q       <= '0;
			cwp_q      <= '0;
			twp_q      <= '0;
			held_q     <= '0;
			left_q     <= '0;
			total_q    <= '0;
			drop_q     <= 1'b0;
			eos_q      <= 1'b0;
			shut_q     <= 1'b0;
			cnt_q      <= '0;
			byte_sel_q <= 1'b0;
			done       <= 1'b0;
			status     <= pdbrf_pkg::ST_ACCEPT;
			run_last   <= 1'b0;
			byte_count <= '0;
			occupancy  <= '0;
		end else begin
			done       <= 1'b0;
			byte_sel_q <= 1'b0;

			// read data run, one fetch a cycle
			if (issue) begin
				rp_q       <= ptr_inc(rp_q);
				done       <= 1'b1;
				byte_sel_q <= 1'b1;
				status     <= pdbrf_pkg::ST_DATA;
				run_last   <= (remain == RW'(1));
				if (state_q == S_IDLE) begin
					held_q     <= held_read;
					occupancy  <= LW'(held_read);
					byte_count <= LW'(n_rd);
					cnt_q      <= n_rd - RW'(1);
					if (n_rd != RW'(1)) begin
						state_q <= S_READ;
					end
				end else begin
					cnt_q <= cnt_q - RW'(1);
					if (cnt_q == RW'(1)) begin
						state_q <= S_IDLE;
					end
				end
			end else if (rd_req) begin
				// nothing to read: one status word
				done       <= 1'b1;
				run_last   <= 1'b1;
				byte_count <= '0;
				occupancy  <= LW'(held_q);
				if (shut_q) begin
					status <= pdbrf_pkg::ST_SHUT;
				end else if (eos_q) begin
					status <= pdbrf_pkg::ST_EOS;
				end else begin
					status <= pdbrf_pkg::ST_EMPTY;
				end
			end

			// packet bytes
			if (is_wr && start_zero) begin
				twp_q      <= cwp_q;
				left_q     <= '0;
				total_q    <= '0;
				drop_q     <= 1'b0;
				done       <= 1'b1;
				status     <= pdbrf_pkg::ST_DROP;
				run_last   <= 1'b1;
				byte_count <= '0;
				occupancy  <= LW'(held_q);
			end else if (wr_active) begin
				left_q  <= left_next;
				total_q <= eff_total;
				drop_q  <= eff_drop;
				twp_q   <= twp_next;
				if (finish) begin
					done     <= 1'b1;
					run_last <= 1'b1;
					if (eff_drop) begin
						drop_q     <= 1'b0;
						twp_q      <= cwp_q;
						status     <= pdbrf_pkg::ST_DROP;
						byte_count <= '0;
						occupancy  <= LW'(held_q);
					end else begin
						cwp_q      <= twp_next;
						held_q     <= held_commit;
						status     <= pdbrf_pkg::ST_ACCEPT;
						byte_count <= eff_total;
						occupancy  <= LW'(held_commit);
					end
				end
			end

			// flags and clear
			if (accept && (req_type == pdbrf_pkg::REQ_EOS)) begin
				eos_q <= 1'b1;
			end
			if (accept && (req_type == pdbrf_pkg::REQ_SHUT)) begin
				shut_q <= 1'b1;
			end
			if (accept && (req_type == pdbrf_pkg::REQ_CLEAR)) begin
				rp_q    <= '0;
				cwp_q   <= '0;
				twp_q   <= '0;
				held_q  <= '0;
				left_q  <= '0;
				total_q <= '0;
				drop_q  <= 1'b0;
			end
		end
	end

	assign out_byte = byte_sel_q ? mem_rdata : '0;

	pdbrf_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (wr_mem),
		.waddr (eff_twp),
		.wdata (data_byte),
		.re    (issue),
		.raddr (rp_q),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

>>> hdl/pdbrf_chk.sv
// port checker for the packet drop byte ring fifo, bound to the top level
// depends on pdbrf_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdbrf_chk (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic [pdbrf_pkg::REQ_W-1:0]   req_type,
	input wire logic                          pkt_start,
	input wire logic [pdbrf_pkg::LEN_W-1:0]   pkt_len,
	input wire logic                          done,
	input wire logic [pdbrf_pkg::STAT_W-1:0]  status,
	input wire logic                          run_last,
	input wire logic [pdbrf_pkg::LEN_W-1:0]   byte_count
);

	// every status word other than read data closes its request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != pdbrf_pkg::ST_DATA) |-> run_last)
		else $error("non-data word without last mark");

	// while a read run holds the port a data word follows every cycle
	a_busy_data: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && (status == pdbrf_pkg::ST_DATA))
		else $error("read run missed a data word");

	// a run continues with the same byte count until its last word
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		done && !run_last |=> done && (status == pdbrf_pkg::ST_DATA) && $stable(byte_count))
		else $error("read run broken");

	// a zero length start byte is dropped at once
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == pdbrf_pkg::REQ_WRITE) && pkt_start && (pkt_len == '0)
		|=> done && (status == pdbrf_pkg::ST_DROP) && (byte_count == '0))
		else $error("zero length packet not dropped");

endmodule

bind packet_drop_byte_ring_fifo pdbrf_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.req_type   (req_type),
	.pkt_start  (pkt_start),
	.pkt_len    (pkt_len),
	.done       (done),
	.status     (status),
	.run_last   (run_last),
	.byte_count (byte_count)
);

`default_nettype wire

>>> verif/tb.sv
// self-checking testbench for packet_drop_byte_ring_fifo: random bursts of request words,
// results predicted by a shadow ring model in the testbench; depends on pdbrf_pkg and the rtl
`timescale 1ns / 1ps

module tb;

	localparam int REQ_W  = pdbrf_pkg::REQ_W;
	localparam int BYTE_W = pdbrf_pkg::BYTE_W;
	localparam int LEN_W  = pdbrf_pkg::LEN_W;
	localparam int RMAX_W = pdbrf_pkg::RMAX_W;
	localparam int STAT_W = pdbrf_pkg::STAT_W;
	localparam int RLIM   = pdbrf_pkg::READ_LIMIT_DEF;

	localparam int CAP         = pdbrf_pkg::DEPTH_DEF - 1;
	localparam int RMAX_TOP    = 2**RMAX_W - 1;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 16;
	localparam int MAX_PRINTS  = 100;

	// request codes the block ignores
	localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [REQ_W-1:0]  req;
		logic [BYTE_W-1:0] data;
		logic              first;
		logic [LEN_W-1:0]  len;
		logic [RMAX_W-1:0] rmax;
	} req_word_t;

	typedef struct packed {
		logic [STAT_W-1:0] stat;
		logic [BYTE_W-1:0] data;
		logic              last;
		logic [LEN_W-1:0]  count;
		logic [LEN_W-1:0]  occ;
	} res_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [REQ_W-1:0]  req_type = pdbrf_pkg::REQ_WRITE;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              pkt_start = 1'b0;
	logic [LEN_W-1:0]  pkt_len = '0;
	logic [RMAX_W-1:0] read_max = '0;
	logic              busy;
	logic              done;
	logic [STAT_W-1:0] status;
	logic [BYTE_W-1:0] out_byte;
	logic              run_last;
	logic [LEN_W-1:0]  byte_count;
	logic [LEN_W-1:0]  occupancy;

	req_word_t req_words[$];
	res_word_t due_results[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 8;
	int gap_left = 0;

	// shadow ring state; 12-bit pointers wrap exactly at the default depth
	logic [BYTE_W-1:0] shadow_mem [pdbrf_pkg::DEPTH_DEF];
	logic [LEN_W-1:0]  shadow_rd = '0;
	logic [LEN_W-1:0]  shadow_cwr = '0;
	logic [LEN_W-1:0]  shadow_twr = '0;
	logic [LEN_W-1:0]  shadow_left = '0;
	logic [LEN_W-1:0]  shadow_total = '0;
	logic              shadow_dropping = 1'b0;
	logic              shadow_eos = 1'b0;
	logic              shadow_shut = 1'b0;

	packet_drop_byte_ring_fifo dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.data_byte(data_byte),
		.pkt_start(pkt_start),
		.pkt_len(pkt_len),
		.read_max(read_max),
		.done(done),
		.status(status),
		.out_byte(out_byte),
		.run_last(run_last),
		.byte_count(byte_count),
		.occupancy(occupancy)
	);

	always #4 clk = ~clk;

	function automatic logic [LEN_W-1:0] held_bytes();
		return shadow_cwr - shadow_rd;
	endfunction

	task automatic post_result(input logic [STAT_W-1:0] stat, input logic [BYTE_W-1:0] data,
			input logic last, input logic [LEN_W-1:0] count);
		due_results.push_back('{stat, data, last, count, held_bytes()});
	endtask

	// advance the shadow ring by one accepted word and queue what it should emit
	task automatic ring_step(input req_word_t w);
		logic [LEN_W-1:0] occ;
		logic [LEN_W-1:0] n;
		logic [LEN_W-1:0] idx;
		int lim;
		occ = held_bytes();
		case (w.req)
		pdbrf_pkg::REQ_WRITE: begin
			if (w.first) begin
				shadow_twr = shadow_cwr;
				shadow_total = w.len;
				shadow_left = w.len;
				shadow_dropping = int'(w.len) > CAP - int'(occ);
				if (w.len == 0) begin
					shadow_dropping = 1'b0;
					post_result(pdbrf_pkg::ST_DROP, '0, 1'b1, '0);
					return;
				end
			end else if (shadow_left == 0) begin
				return;
			end
			if (!shadow_dropping) begin
				shadow_mem[shadow_twr] = w.data;
				shadow_twr = shadow_twr + 1'b1;
			end
			shadow_left = shadow_left - 1'b1;
			if (shadow_left == 0) begin
				if (shadow_dropping) begin
					shadow_dropping = 1'b0;
					shadow_twr = shadow_cwr;
					post_result(pdbrf_pkg::ST_DROP, '0, 1'b1, '0);
				end else begin
					shadow_cwr = shadow_twr;
					post_result(pdbrf_pkg::ST_ACCEPT, '0, 1'b1, shadow_total);
				end
			end
		end
		pdbrf_pkg::REQ_READ: begin
			if (w.rmax == 0)
				return;
			if (shadow_shut) begin
				post_result(pdbrf_pkg::ST_SHUT, '0, 1'b1, '0);
			end else if (occ == 0) begin
				post_result(shadow_eos ? pdbrf_pkg::ST_EOS : pdbrf_pkg::ST_EMPTY,
					'0, 1'b1, '0);
			end else begin
				lim = (int'(w.rmax) < RLIM) ? int'(w.rmax) : RLIM;
				n = (int'(occ) < lim) ? occ : LEN_W'(lim);
				idx = shadow_rd;
				shadow_rd = shadow_rd + n;
				for (int i = 0; i < int'(n); i++) begin
					post_result(pdbrf_pkg::ST_DATA, shadow_mem[idx], i == int'(n) - 1, n);
					idx = idx + 1'b1;
				end
			end
		end
		pdbrf_pkg::REQ_EOS: shadow_eos = 1'b1;
		pdbrf_pkg::REQ_SHUT: shadow_shut = 1'b1;
		pdbrf_pkg::REQ_CLEAR: begin
			shadow_rd = '0;
			shadow_cwr = '0;
			shadow_twr = '0;
			shadow_left = '0;
			shadow_total = '0;
			shadow_dropping = 1'b0;
		end
		default: ;
		endcase
	endtask

	function automatic string show(input res_word_t r);
		return $sformatf("status %0d byte %02h last %0d count %0d occ %0d",
			r.stat, r.data, r.last, r.count, r.occ);
	endfunction

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// word with every field random, then the request code forced
	function automatic req_word_t noise(input logic [REQ_W-1:0] req);
		req_word_t w;
		w.req = req;
		w.data = BYTE_W'($urandom);
		w.first = 1'($urandom);
		w.len = LEN_W'($urandom);
		w.rmax = RMAX_W'($urandom);
		return w;
	endfunction

	task automatic add_write(input logic first, input logic [LEN_W-1:0] len,
			input logic [BYTE_W-1:0] data);
		req_word_t w;
		w = noise(pdbrf_pkg::REQ_WRITE);
		w.first = first;
		w.data = data;
		if (first)
			w.len = len;
		req_words.push_back(w);
	endtask

	task automatic add_packet(input int len);
		add_write(1'b1, LEN_W'(len), BYTE_W'($urandom));
		for (int i = 1; i < len; i++)
			add_write(1'b0, '0, BYTE_W'($urandom));
	endtask

	task automatic add_read(input int rmax);
		req_word_t w;
		w = noise(pdbrf_pkg::REQ_READ);
		w.rmax = RMAX_W'(rmax);
		req_words.push_back(w);
	endtask

	task automatic add_op(input logic [REQ_W-1:0] req);
		req_words.push_back(noise(req));
	endtask

	// wait until every word is taken and every expected result has come
	task automatic settle();
		@(negedge clk);
		while (req_words.size() != 0 || start || due_results.size() != 0)
			@(negedge clk);
	endtask

	// driver: sends words in bursts with random gaps
	always @(posedge clk) begin : driver
		req_word_t w;
		logic load;
		load = !start;
		if (start && !busy) begin
			ring_step('{req_type, data_byte, pkt_start, pkt_len, read_max});
			load = 1'b1;
		end
		if (load) begin
			if (arst_n && gap_left == 0 && req_words.size() != 0) begin
				w = req_words.pop_front();
				req_type <= w.req;
				data_byte <= w.data;
				pkt_start <= w.first;
				pkt_len <= w.len;
				read_max <= w.rmax;
				start <= 1'b1;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left--;
				end
			end else begin
				start <= 1'b0;
				if (gap_left != 0)
					gap_left--;
			end
		end
	end

	// monitor: each strobed result against the oldest expectation
	always @(posedge clk) begin : monitor
		res_word_t got;
		res_word_t want;
		if (arst_n && done) begin
			got = '{status, out_byte, run_last, byte_count, occupancy};
			if (due_results.size() == 0) begin
				note_mismatch({"result with none due: ", show(got)});
			end else begin
				want = due_results.pop_front();
				if (got.stat !== want.stat || got.data !== want.data || got.last !== want.last
						|| got.count !== want.count || got.occ !== want.occ)
					note_mismatch({"got ", show(got), " want ", show(want)});
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int issued;
		int pick;
		int len;
		int cut;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty read, stray byte, zero length, byte extremes, read caps
		add_read(1);
		add_write(1'b0, '0, 8'h3c);
		add_write(1'b1, '0, 8'h11);
		add_write(1'b1, 12'd1, 8'hff);
		add_write(1'b1, 12'd3, 8'h00);
		add_write(1'b0, '0, 8'ha5);
		add_write(1'b0, '0, 8'h5a);
		add_read(0);
		add_read(RMAX_TOP);
		add_read(1);
		add_packet(2);
		// oversized start is dropped, then abandoned by a new start
		add_write(1'b1, {LEN_W{1'b1}}, 8'h77);
		add_write(1'b0, '0, 8'h88);
		add_write(1'b1, 12'd1, 8'h99);
		add_read(RLIM);
		for (int c = REQ_UNUSED_LO; c <= REQ_UNUSED_HI; c++)
			add_op(REQ_W'(c));
		// clear with a packet open, then a byte that finds none open
		add_write(1'b1, 12'd3, 8'h42);
		add_op(pdbrf_pkg::REQ_CLEAR);
		add_write(1'b0, '0, 8'h24);
		add_packet(1);
		add_read(2);
		settle();

		// random: mostly whole packets and reads, some noise
		issued = 0;
		while (issued < 210) begin
			pick = $urandom_range(0, 99);
			if (pick < 48) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
				add_packet(len);
				issued += len;
			end else if (pick < 78) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					add_read($urandom_range(1, 16));
				else if (pick < 9)
					add_read($urandom_range(17, RMAX_TOP));
				else
					add_read(0);
				issued++;
			end else if (pick < 86) begin
				len = $urandom_range(3, 12);
				cut = $urandom_range(1, len - 1);
				add_write(1'b1, LEN_W'(len), BYTE_W'($urandom));
				repeat (cut - 1) add_write(1'b0, '0, BYTE_W'($urandom));
				issued += cut;
			end else if (pick < 90) begin
				add_write(1'b0, '0, BYTE_W'($urandom));
			end else if (pick < 93) begin
				add_write(1'b1, '0, BYTE_W'($urandom));
				issued++;
			end else if (pick < 96) begin
				add_op(pdbrf_pkg::REQ_CLEAR);
				issued++;
			end else begin
				add_op(REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)));
			end
		end
		settle();

		// fill to capacity across the pointer wrap, then packets that no longer fit
		if (held_bytes() != CAP)
			add_packet(CAP - int'(held_bytes()));
		add_packet(1);
		add_packet(2);
		add_read(RMAX_TOP);
		add_packet(RLIM + 1);
		add_packet(RLIM);
		add_write(1'b1, {LEN_W{1'b1}}, BYTE_W'($urandom));
		add_write(1'b0, '0, BYTE_W'($urandom));
		add_packet(1);
		// drain everything, one extra read finds it empty
		repeat (CAP / RLIM + 2) add_read(RMAX_TOP);
		// end of stream, then shutdown for the rest of the run
		add_op(pdbrf_pkg::REQ_EOS);
		add_read(1);
		add_packet(2);
		add_read(1);
		add_op(pdbrf_pkg::REQ_SHUT);
		add_read(1);
		add_packet(1);
		add_read(0);
		add_op(pdbrf_pkg::REQ_CLEAR);
		add_read(RMAX_TOP);
		settle();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && due_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
